@@ rtl/core/u16d_pkg.sv @@
// Shared types and constants for the UTF-16 byte decoder.
`default_nettype none
package u16d_pkg;

  // Unit values with special handling
  localparam logic [15:0] BOM_UNIT  = 16'hFEFF;
  localparam logic [15:0] CR_UNIT   = 16'h000D;
  localparam logic [15:0] SURR_MASK = 16'hF800;
  localparam logic [15:0] SURR_BASE = 16'hD800;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [20:0] CP_MAX    = 21'h10FFFF;

  // Unit queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Configuration register map
  localparam int ADDR_W = 3;
  localparam logic REG_BIG_ENDIAN = 1'b0;
  localparam logic REG_DROP_CR    = 1'b1;

  typedef struct packed {
    logic        valid;
    logic [15:0] unit;
  } unit_push_t;

  typedef struct packed {
    logic        big_endian;
    logic        drop_cr;
  } cfg_t;

endpackage
`default_nettype wire

@@ rtl/core/u16d_front.sv @@
// Front end: byte pairing into 16-bit units and drop classification.
`default_nettype none
module u16d_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire u16d_pkg::cfg_t     cfg,
  input  wire logic               accept,
  input  wire logic [7:0]         byte_in,
  output u16d_pkg::unit_push_t    push_o
);

  logic        phase_r, phase_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] shifted;
  logic        drop;

  // Shift the new byte in according to the current byte order
  assign shifted = cfg.big_endian ? {acc_r[7:0], byte_in} : {byte_in, acc_r[15:8]};
  assign drop = (shifted == u16d_pkg::BOM_UNIT) ||
                (cfg.drop_cr && (shifted == u16d_pkg::CR_UNIT));

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    if (accept) begin
      if (!phase_r) begin
        phase_nxt = 1'b1;
        acc_nxt   = shifted;
      end else begin
        phase_nxt = 1'b0;
        acc_nxt   = '0;
      end
    end
  end

  assign push_o.valid = accept && phase_r && !drop;
  assign push_o.unit  = shifted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      acc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/u16d_queue.sv @@
// Short unit queue decoupling the front end from the back end.
`default_nettype none
module u16d_queue (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire u16d_pkg::unit_push_t push_i,
  input  wire logic                 pop,
  output logic                      full,
  output logic                      not_empty,
  output logic [15:0]               head
);

  logic [15:0]                   mem [u16d_pkg::QDEPTH];
  logic [u16d_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [u16d_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                          do_push, do_pop;

  assign full      = (cnt_r == u16d_pkg::QCNT_W'(u16d_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push_i.valid && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_i.unit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/u16d_back.sv @@
// Back end: surrogate pairing and the result register.
`default_nettype none
module u16d_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_not_empty,
  input  wire logic [15:0] q_head,
  output logic             q_pop,
  input  wire logic        out_pop,
  output logic             out_valid,
  output logic [20:0]      out_cp
);

  logic        out_valid_r, out_valid_nxt;
  logic [20:0] out_cp_r, out_cp_nxt;
  logic        pend_r, pend_nxt;
  logic [9:0]  pend_bits_r;
  logic        is_surr;
  logic        hold_surr;

  assign is_surr   = (q_head & u16d_pkg::SURR_MASK) == u16d_pkg::SURR_BASE;
  // Take a unit whenever the result register is free or being drained
  assign q_pop     = q_not_empty && (!out_valid_r || out_pop);
  assign hold_surr = q_pop && !pend_r && is_surr;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_pop;
    out_cp_nxt    = out_cp_r;
    pend_nxt      = pend_r;
    if (q_pop) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_cp_nxt    = u16d_pkg::SUPP_BASE + {1'b0, pend_bits_r, q_head[9:0]};
        pend_nxt      = 1'b0;
      end else if (is_surr) begin
        pend_nxt      = 1'b1;
      end else begin
        out_valid_nxt = 1'b1;
        out_cp_nxt    = {5'b0, q_head};
      end
    end
  end

  always_ff @(posedge clk) begin
    out_cp_r <= out_cp_nxt;
    if (hold_surr) pend_bits_r <= q_head[9:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_cp    = out_cp_r;

`ifndef SYNTHESIS
  a_pair_gives_supp: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop && pend_r |=> out_valid_r && (out_cp_r >= u16d_pkg::SUPP_BASE) && !pend_r)
    else $error("paired surrogate did not give a supplementary code point");

  a_cp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cp_r <= u16d_pkg::CP_MAX)
    else $error("code point out of range");

  a_hold_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    hold_surr |=> pend_r && !out_valid_r)
    else $error("held surrogate produced a result");
`endif

endmodule
`default_nettype wire

@@ rtl/core/utf16_byte_decoder.sv @@
// Top level of the UTF-16 byte-stream decoder with its APB configuration port.
// Path: a code point is written into the unit queue on the edge that accepts the second
//   byte of its last unit, then into the result register once that register is free.
// Throughput: one byte per cycle while results are popped; set by the front end's
//   single byte shift, a 2-entry unit queue and the surrogate pairing stage.
// Reset: synchronous, active low; byte order big endian, CR drop off, no surrogate pending.
`default_nettype none
module utf16_byte_decoder (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // input channel
  input  wire logic                        push,
  output logic                             full,
  input  wire logic [7:0]                  in_byte_in,
  // result channel
  output logic                             empty,
  input  wire logic                        pop,
  output logic [20:0]                      out_code_point,
  // configuration port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [u16d_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  u16d_pkg::cfg_t       cfg_r, cfg_nxt;
  u16d_pkg::unit_push_t unit_push;
  logic                 cfg_wr;
  logic                 reg_idx;
  logic                 accept;
  logic                 q_full, q_not_empty, q_pop;
  logic [15:0]          q_head;
  logic                 res_valid;

  // ---------------------------------------------------------------------------
  // Configuration: registers sit at byte offsets 0 and 4, so bit 2 picks one.
  // Only bit 0 of the written data is kept. pready is tied high (no wait states).
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_idx)
        u16d_pkg::REG_BIG_ENDIAN: cfg_nxt.big_endian = pwdata[0];
        u16d_pkg::REG_DROP_CR:    cfg_nxt.drop_cr    = pwdata[0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      u16d_pkg::REG_BIG_ENDIAN: prdata = {31'b0, cfg_r.big_endian};
      u16d_pkg::REG_DROP_CR:    prdata = {31'b0, cfg_r.drop_cr};
      default:                  prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.big_endian <= 1'b1;
      cfg_r.drop_cr    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Front end: accept a byte whenever the unit queue has room. Full is a
  // registered count compare, so it has no combinational path from the result side.
  // ---------------------------------------------------------------------------
  assign full   = q_full;
  assign accept = push && !full;

  u16d_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .accept  (accept),
    .byte_in (in_byte_in),
    .push_o  (unit_push)
  );

  // Decouple classification from surrogate pairing
  u16d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (unit_push),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // ---------------------------------------------------------------------------
  // Back end: pair surrogates and hold the oldest result until popped. A new
  // unit is taken in the same cycle as the waiting transaction drains.
  // ---------------------------------------------------------------------------
  u16d_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_pop     (pop),
    .out_valid   (res_valid),
    .out_cp      (out_code_point)
  );

  assign empty = !res_valid;

endmodule
`default_nettype wire

@@ sim/utf16_decode_checker.sv @@
`timescale 1ns / 1ps
// Checker for the UTF-16 byte decoder: predicts code points from the byte stream and compares.
module utf16_decode_checker (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        push,
  input  wire logic                        full,
  input  wire logic [7:0]                  in_byte_in,
  input  wire logic                        empty,
  input  wire logic                        pop,
  input  wire logic [20:0]                 out_code_point,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic                        pready,
  input  wire logic [u16d_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output int                               fail_count,
  output int                               pending_count
);

  logic [20:0]     expected_code_points[$];
  u16d_pkg::cfg_t  mode;
  logic            second_byte;
  logic [15:0]     unit_acc;
  logic [15:0]     held_high;
  int              fails;

  // Advance the decoder state by one byte; queue a code point if one completes.
  function automatic void decode_byte(input logic [7:0] b);
    logic [15:0] unit;
    if (mode.big_endian) unit_acc = {unit_acc[7:0], b};
    else                 unit_acc = {b, unit_acc[15:8]};
    if (!second_byte) begin
      second_byte = 1'b1;
      return;
    end
    unit        = unit_acc;
    second_byte = 1'b0;
    unit_acc    = '0;
    if (unit == u16d_pkg::BOM_UNIT || (mode.drop_cr && unit == u16d_pkg::CR_UNIT)) return;
    if (held_high != 16'h0) begin
      expected_code_points.push_back(u16d_pkg::SUPP_BASE +
                                     {1'b0, held_high[9:0], unit[9:0]});
      held_high = '0;
    end else if ((unit & u16d_pkg::SURR_MASK) == u16d_pkg::SURR_BASE) begin
      held_high = unit;
    end else begin
      expected_code_points.push_back({5'b0, unit});
    end
  endfunction

  always @(posedge clk) begin
    logic [20:0]                   want;
    logic [u16d_pkg::ADDR_W-3:0]   reg_index;
    if (!rst_n) begin
      mode.big_endian = 1'b1;
      mode.drop_cr    = 1'b0;
      second_byte     = 1'b0;
      unit_acc        = '0;
      held_high       = '0;
      fails           = 0;
      expected_code_points.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        reg_index = paddr[u16d_pkg::ADDR_W-1:2];
        if (reg_index == u16d_pkg::REG_BIG_ENDIAN) mode.big_endian = pwdata[0];
        else if (reg_index == u16d_pkg::REG_DROP_CR) mode.drop_cr = pwdata[0];
      end
      if (pop && !empty) begin
        if (expected_code_points.size() == 0) begin
          $display("%0t: unexpected code point, expected none, got %h", $time, out_code_point);
          fails++;
        end else begin
          want = expected_code_points.pop_front();
          if (out_code_point !== want) begin
            $display("%0t: code point mismatch, expected %h, got %h",
                     $time, want, out_code_point);
            fails++;
          end
        end
      end
      if (push && !full) decode_byte(in_byte_in);
    end
    fail_count    <= fails;
    pending_count <= expected_code_points.size();
  end

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Top of the UTF-16 byte decoder testbench: clock, reset, stimulus and verdict.
module tb_top;

  localparam int STALL_LIMIT  = 3000;  // cycles without any transaction
  localparam int LONG_HOLD    = 400;   // receiver hold-off that backs the block up
  localparam int PHASE_BYTES  = 200;
  localparam int PHASE_COUNT  = 8;
  localparam int SETTLE_TICKS = 8;     // covers the pipeline with margin

  logic                          clk;
  logic                          rst_n;
  logic                          push;
  logic                          full;
  logic [7:0]                    in_byte_in;
  logic                          empty;
  logic                          pop;
  logic [20:0]                   out_code_point;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [u16d_pkg::ADDR_W-1:0]   paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  int   fail_count;
  int   pending_count;
  int   stall_ticks;
  bit   tx_idle_en;
  bit   rx_idle_en;
  bit   hold_req;
  logic tx_big_endian;  // byte order the stimulus currently encodes in

  utf16_byte_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_byte_in     (in_byte_in),
    .empty          (empty),
    .pop            (pop),
    .out_code_point (out_code_point),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  utf16_decode_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_byte_in     (in_byte_in),
    .empty          (empty),
    .pop            (pop),
    .out_code_point (out_code_point),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .fail_count     (fail_count),
    .pending_count  (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Count cycles in which no transaction of any kind completes.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (psel && penable && pready))
      stall_ticks <= 0;
    else
      stall_ticks <= stall_ticks + 1;
  end

  // Watchdog: give up once the block has sat still for too long.
  initial begin
    stall_ticks = 0;
    wait (stall_ticks >= STALL_LIMIT);
    $display("[utf16_byte_decoder] ERROR");
    $finish;
  end

  // Result side: pop freely, stall in random bursts, and on request hold off
  // for a long stretch so that the block fills up and pushes back.
  initial begin
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one byte, with an optional random gap first; return once accepted.
  // push stays high afterwards so that back-to-back bytes follow without a gap.
  task automatic push_byte(input logic [7:0] b);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    push       <= 1'b1;
    in_byte_in <= b;
    do @(posedge clk); while (full);
  endtask

  // Send a 16-bit unit in the byte order the block is set to.
  task automatic send_unit(input logic [15:0] unit);
    if (tx_big_endian) begin
      push_byte(unit[15:8]);
      push_byte(unit[7:0]);
    end else begin
      push_byte(unit[7:0]);
      push_byte(unit[15:8]);
    end
  endtask

  // Stop offering bytes, drain every expected code point, then let dropped
  // units still in the pipeline clear out.
  task automatic drain_block();
    push <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Two-phase register write; junk in the upper bits must be ignored.
  task automatic write_reg(input logic idx, input logic value);
    logic [31:0] word;
    word     = $urandom;
    word[0]  = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == u16d_pkg::REG_BIG_ENDIAN) tx_big_endian = value;
  endtask

  // One random transaction group: mostly well-formed text, some noise.
  task automatic send_random(output int sent);
    int          pick;
    logic [15:0] unit;
    pick = $urandom_range(0, 99);
    sent = 2;
    if (pick < 45) begin
      unit = 16'($urandom);
      if (unit[15:11] == 5'b11011) unit[15] = 1'b0;  // keep it outside the surrogate range
      send_unit(unit);
    end else if (pick < 65) begin
      unit = 16'hD800 | 16'($urandom_range(0, 1023));
      send_unit(unit);
      unit = 16'hDC00 | 16'($urandom_range(0, 1023));
      send_unit(unit);
      sent = 4;
    end else if (pick < 72) begin
      send_unit(u16d_pkg::BOM_UNIT);
    end else if (pick < 80) begin
      send_unit(u16d_pkg::CR_UNIT);
    end else if (pick < 87) begin
      unit = 16'hD800 | 16'($urandom_range(0, 2047));  // lone high or low surrogate
      send_unit(unit);
    end else if (pick < 93) begin
      push_byte(8'($urandom_range(0, 255)));           // odd byte shifts the pairing
      sent = 1;
    end else begin
      send_unit(16'($urandom));
    end
  endtask

  initial begin
    int sent;
    int phase_bytes;
    rst_n         <= 1'b0;
    push          <= 1'b0;
    in_byte_in    <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    hold_req      = 1'b0;
    tx_big_endian = 1'b1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: big endian, carriage returns kept.
    send_unit(16'h0000);
    send_unit(u16d_pkg::BOM_UNIT);  // byte order mark is swallowed
    send_unit(u16d_pkg::CR_UNIT);   // carriage return passes while drop is off
    send_unit(16'hD83D);
    send_unit(16'hDE00);            // ordinary surrogate pair
    send_unit(16'hDBFF);
    send_unit(u16d_pkg::BOM_UNIT);  // dropped unit leaves the high half pending
    send_unit(16'hDFFF);            // largest code point
    send_unit(16'hD801);
    send_unit(16'hD802);            // high after high is still combined
    send_unit(16'hFFFF);
    drain_block();

    write_reg(u16d_pkg::REG_DROP_CR, 1'b1);
    write_reg(u16d_pkg::REG_BIG_ENDIAN, 1'b0);
    send_unit(u16d_pkg::CR_UNIT);   // now dropped
    send_unit(16'hDC00);            // lone low surrogate is held as well
    send_unit(u16d_pkg::CR_UNIT);   // dropped while pending
    send_unit(16'h0041);            // non-surrogate combined with the held unit
    push_byte(8'h12);
    drain_block();
    write_reg(u16d_pkg::REG_BIG_ENDIAN, 1'b1); // flip byte order between the two bytes
    push_byte(8'h34);
    drain_block();

    // Random phases, walking every combination of the two registers.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      write_reg(u16d_pkg::REG_BIG_ENDIAN, ph[0] ? 1'b0 : 1'b1);
      write_reg(u16d_pkg::REG_DROP_CR, ph[1]);
      if (ph == 2) hold_req = 1'b1;
      if (ph == PHASE_COUNT - 1) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        send_random(sent);
        phase_bytes += sent;
      end
      drain_block();
    end

    if (fail_count == 0 && pending_count == 0) begin
      $display("[utf16_byte_decoder] OK");
    end else begin
      $display("[utf16_byte_decoder] ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/u16d_pkg.sv
rtl/core/u16d_front.sv
rtl/core/u16d_queue.sv
rtl/core/u16d_back.sv
rtl/core/utf16_byte_decoder.sv
sim/utf16_decode_checker.sv
sim/tb_top.sv
